@@ rtl/jost_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package jost_pkg;

    // Characters the tokenizer reacts to
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // Counter width for the nesting depth
    localparam int DEPTH_W = 4;

    // Parser state, one-hot
    typedef enum logic [7:0] {
        ST_START        = 8'b0000_0001,
        ST_KEY_OR_END   = 8'b0000_0010,
        ST_IN_KEY       = 8'b0000_0100,
        ST_COLON        = 8'b0000_1000,
        ST_VALUE        = 8'b0001_0000,
        ST_IN_VALUE     = 8'b0010_0000,
        ST_COMMA_OR_END = 8'b0100_0000,
        ST_DONE         = 8'b1000_0000
    } t_state;

    // Event codes carried on the result channel
    typedef enum logic [3:0] {
        EV_SKIP       = 4'd0,
        EV_ROOT_OPEN  = 4'd1,
        EV_NEST_OPEN  = 4'd2,
        EV_KEY_START  = 4'd3,
        EV_KEY_CHAR   = 4'd4,
        EV_KEY_END    = 4'd5,
        EV_VAL_START  = 4'd6,
        EV_VAL_CHAR   = 4'd7,
        EV_VAL_END    = 4'd8,
        EV_SEP        = 4'd9,
        EV_NEST_CLOSE = 4'd10,
        EV_ROOT_CLOSE = 4'd11,
        EV_REJECT     = 4'd12,
        EV_OVERFLOW   = 4'd13
    } t_event;

    // One result beat
    typedef struct packed {
        t_event               ev;
        logic [7:0]           ch;
        logic [DEPTH_W-1:0]   depth;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/jost_step.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Parser state and the per-character transition logic.
module jost_step #(
    parameter int MAX_DEPTH = 15
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire logic [7:0]       i_ch,
    input  wire logic             i_strict,
    output jost_pkg::t_result     o_result
);

    localparam logic [jost_pkg::DEPTH_W-1:0] DepthLimit =
        (MAX_DEPTH > 15) ? 4'd15 : jost_pkg::DEPTH_W'(MAX_DEPTH);

    jost_pkg::t_state           r_state, n_state;
    logic [jost_pkg::DEPTH_W-1:0] r_depth, n_depth;
    jost_pkg::t_event           n_event;
    logic                       blank;
    logic                       unexpected;

    assign blank = (i_ch == jost_pkg::CH_SPACE) || (i_ch == jost_pkg::CH_TAB) ||
                   (i_ch == jost_pkg::CH_LF)    || (i_ch == jost_pkg::CH_CR);

    // Transition and event for the current character
    always_comb begin
        n_state    = r_state;
        n_depth    = r_depth;
        n_event    = jost_pkg::EV_SKIP;
        unexpected = 1'b0;
        if (r_state == jost_pkg::ST_IN_KEY) begin
            if (i_ch == jost_pkg::CH_QUOTE) begin
                n_state = jost_pkg::ST_COLON;
                n_event = jost_pkg::EV_KEY_END;
            end else begin
                n_event = jost_pkg::EV_KEY_CHAR;
            end
        end else if (r_state == jost_pkg::ST_IN_VALUE) begin
            if (i_ch == jost_pkg::CH_QUOTE) begin
                n_state = jost_pkg::ST_COMMA_OR_END;
                n_event = jost_pkg::EV_VAL_END;
            end else begin
                n_event = jost_pkg::EV_VAL_CHAR;
            end
        end else if (blank) begin
            n_event = jost_pkg::EV_SKIP;
        end else begin
            unexpected = 1'b1;
            unique case (r_state)
                jost_pkg::ST_START: begin
                    if (i_ch == jost_pkg::CH_LBRACE) begin
                        n_state    = jost_pkg::ST_KEY_OR_END;
                        n_event    = jost_pkg::EV_ROOT_OPEN;
                        unexpected = 1'b0;
                    end
                end
                jost_pkg::ST_KEY_OR_END, jost_pkg::ST_COMMA_OR_END: begin
                    if (i_ch == jost_pkg::CH_QUOTE && r_state == jost_pkg::ST_KEY_OR_END) begin
                        n_state    = jost_pkg::ST_IN_KEY;
                        n_event    = jost_pkg::EV_KEY_START;
                        unexpected = 1'b0;
                    end else if (i_ch == jost_pkg::CH_COMMA &&
                                 r_state == jost_pkg::ST_COMMA_OR_END) begin
                        n_state    = jost_pkg::ST_KEY_OR_END;
                        n_event    = jost_pkg::EV_SEP;
                        unexpected = 1'b0;
                    end else if (i_ch == jost_pkg::CH_RBRACE) begin
                        unexpected = 1'b0;
                        // closing the root ends the document
                        if (r_depth == '0) begin
                            n_state = jost_pkg::ST_DONE;
                            n_event = jost_pkg::EV_ROOT_CLOSE;
                        end else begin
                            n_depth = r_depth - jost_pkg::DEPTH_W'(1);
                            n_state = jost_pkg::ST_COMMA_OR_END;
                            n_event = jost_pkg::EV_NEST_CLOSE;
                        end
                    end
                end
                jost_pkg::ST_COLON: begin
                    if (i_ch == jost_pkg::CH_COLON) begin
                        n_state    = jost_pkg::ST_VALUE;
                        n_event    = jost_pkg::EV_SEP;
                        unexpected = 1'b0;
                    end
                end
                jost_pkg::ST_VALUE: begin
                    if (i_ch == jost_pkg::CH_QUOTE) begin
                        n_state    = jost_pkg::ST_IN_VALUE;
                        n_event    = jost_pkg::EV_VAL_START;
                        unexpected = 1'b0;
                    end else if (i_ch == jost_pkg::CH_LBRACE) begin
                        unexpected = 1'b0;
                        // too deep: brace dropped, state kept
                        if (r_depth >= DepthLimit) begin
                            n_event = jost_pkg::EV_OVERFLOW;
                        end else begin
                            n_depth = r_depth + jost_pkg::DEPTH_W'(1);
                            n_state = jost_pkg::ST_KEY_OR_END;
                            n_event = jost_pkg::EV_NEST_OPEN;
                        end
                    end
                end
                default: begin
                    // done, and the string states handled above
                end
            endcase
        end
        if (unexpected) begin
            n_event = i_strict ? jost_pkg::EV_REJECT : jost_pkg::EV_SKIP;
        end
    end

    assign o_result.ev    = n_event;
    assign o_result.ch    = i_ch;
    assign o_result.depth = n_depth;

    // State registers advance on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= jost_pkg::ST_START;
            r_depth <= '0;
        end else if (i_load) begin
            r_state <= n_state;
            r_depth <= n_depth;
        end
    end

endmodule

`default_nettype wire

@@ rtl/jost_skid.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Output register with one skid entry that takes one further beat while the output is held.
module jost_skid (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire jost_pkg::t_result i_data,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output jost_pkg::t_result     o_data
);

    logic              r_out_valid, n_out_valid;
    logic              r_skid_valid, n_skid_valid;
    jost_pkg::t_result r_out, n_out;
    jost_pkg::t_result r_skid, n_skid;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // Output stage refills from the skid entry first, then from the input
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (i_ready || !r_out_valid) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out        = i_data;
                n_out_valid  = i_valid;
            end
        end else if (i_valid && !r_skid_valid) begin
            n_skid       = i_data;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

endmodule

`default_nettype wire

@@ rtl/json_object_string_tokenizer.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Streaming tokenizer for JSON objects with string keys and string or
// object values. One character byte enters per beat on the s_axis side and
// one event beat leaves on the m_axis side for every character.
// Throughput: one character per cycle while m_axis_tready stays high; the parser state update
// is a single table-like step from the state registers to the result.
// Each event is registered in the output register before it leaves on m_axis
// (by way of the skid entry when the output beat is held).
// Stall: when m_axis_tready is low, one further character is still taken
// into a skid entry; s_axis_tready then drops until the receiver drains it.
// Reset (synchronous, i_rst_n low): parser back to expecting the opening
// brace, depth zero, strict checking off, both output entries empty.
// i_cfg_we/i_cfg_wdata write the strict-check flag; write only while idle.
// MAX_DEPTH sets the nesting limit (effective limit capped at 15); a
// deeper '{' yields the depth-overflow event and is dropped.
module json_object_string_tokenizer #(
    parameter int MAX_DEPTH = 15
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] ch
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [7:0] char_out, [11:8] depth, [15:12] zero
    output logic [3:0]       m_axis_tuser    // [3:0] event_res
);

    localparam logic [jost_pkg::DEPTH_W-1:0] DepthLimit =
        (MAX_DEPTH > 15) ? 4'd15 : jost_pkg::DEPTH_W'(MAX_DEPTH);

    logic              r_strict;
    logic              in_accept;
    jost_pkg::t_result step_result;
    jost_pkg::t_result out_result;

    // Strict-check register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strict <= 1'b0;
        end else if (i_cfg_we) begin
            r_strict <= i_cfg_wdata;
        end
    end

    assign in_accept = s_axis_tvalid && s_axis_tready;

    jost_step #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (in_accept),
        .i_ch     (s_axis_tdata),
        .i_strict (r_strict),
        .o_result (step_result)
    );

    jost_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (step_result),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (out_result)
    );

    // Pack the result beat
    assign m_axis_tdata = {4'b0000, out_result.depth, out_result.ch};
    assign m_axis_tuser = out_result.ev;

    // Skid entry only fills behind a held output beat
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("skid entry full while output register empty");

    // Depth never passes the limit
    a_depth_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[11:8] <= DepthLimit))
        else $error("nesting depth beyond limit");

    // Overflow only reported at the limit
    a_overflow_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == jost_pkg::EV_OVERFLOW)
            |-> (m_axis_tdata[11:8] == DepthLimit))
        else $error("depth overflow below the limit");

    // Root close leaves depth at zero
    a_root_close_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == jost_pkg::EV_ROOT_CLOSE)
            |-> (m_axis_tdata[11:8] == 4'd0))
        else $error("root close with non-zero depth");

endmodule

`default_nettype wire
